// ----- rtl/core/lzss_pkg.sv -----
`default_nettype none

package lzss_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int BYTE_W = 8;
  localparam int CNT_W = 16;
  localparam int OFF_W = 12;
  localparam int LEN_W = 5;

  localparam logic [CNT_W-1:0] MAX_OUTPUT_RESET = 16'hffff;
  localparam logic [3:0] FLAG_COUNT = 4'd8;
  localparam logic [LEN_W-1:0] LEN_BIAS = 5'd3;

  // Where the decoder stands in the compressed stream.
  typedef enum logic [1:0] {
    PH_CONTROL,
    PH_ITEM,
    PH_TOKEN_HIGH
  } phase_t;

endpackage

`default_nettype wire

// ----- rtl/core/lzss_if.sv -----
`default_nettype none

interface lzss_in_if import lzss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzss_out_if import lzss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              data_valid;
  logic              run_last;
  logic              stream_end;
  logic [CNT_W-1:0]  total_out;

  modport source (output valid, output out_byte, output data_valid, output run_last,
                  output stream_end, output total_out, input ready);
  modport sink (input valid, input out_byte, input data_valid, input run_last,
                input stream_end, input total_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lzss_ram.sv -----
`default_nettype none

module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lzss_stream_decompressor_unit.sv -----
// A control byte or a token low byte only updates the decoder state. A literal is held
// in lit_byte and then registered at the output; a match token starts a history RAM
// read whose data is then registered at the output. Input is taken only while idle, so
// no new item is taken until every result of the current one has been sent.
// Reset (rst, synchronous) clears the stream state and sets max_output to 65535;
// the history RAM is not cleared.
`default_nettype none

module lzss_stream_decompressor_unit import lzss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data,
  lzss_in_if.sink                in_ch,
  lzss_out_if.source             out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_COPY,
    ST_END
  } state_t;

  state_t            state;
  phase_t            phase;
  logic [CNT_W-1:0]  max_output;
  logic [CNT_W-1:0]  out_count;
  logic [BYTE_W-1:0] flag_bits;
  logic [3:0]        flags_left;
  logic [BYTE_W-1:0] token_low;
  logic              halted;
  logic              last_q;
  logic [BYTE_W-1:0] lit_byte;
  logic [ADDR_W-1:0] src;
  logic [LEN_W-1:0]  remaining;
  logic              inside_q;
  logic              fwd_hit;
  logic [BYTE_W-1:0] fwd_data;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_dv;
  logic              out_run_last;
  logic              out_end;
  logic [CNT_W-1:0]  out_total;

  logic              accept;
  logic              slot_free;
  logic [15:0]       token;
  logic [OFF_W-1:0]  offset;
  logic [LEN_W-1:0]  copy_len;
  logic              ref_inside;
  logic [ADDR_W-1:0] src_start;
  logic [ADDR_W-1:0] src_step;
  logic [CNT_W-1:0]  count_inc;
  logic              halt_now;
  logic              copy_stop;
  logic [BYTE_W-1:0] ram_q;
  logic [BYTE_W-1:0] copy_byte;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [BYTE_W-1:0] wr_data;
  logic [BYTE_W-1:0] flag_shift;
  logic [3:0]        flags_dec;
  phase_t            phase_after;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid || out_ch.ready;

  assign token = {in_ch.in_byte, token_low};
  assign offset = token[15:4];
  assign copy_len = {1'b0, token[3:0]} + LEN_BIAS;
  assign ref_inside = {{(CNT_W-OFF_W){1'b0}}, offset} < out_count;
  assign src_start = out_count[ADDR_W-1:0] - offset - {{(ADDR_W-1){1'b0}}, 1'b1};
  assign src_step = src + {{(ADDR_W-1){1'b0}}, 1'b1};

  assign count_inc = out_count + {{(CNT_W-1){1'b0}}, 1'b1};
  assign halt_now = count_inc >= max_output;
  assign copy_stop = (remaining == {{(LEN_W-1){1'b0}}, 1'b1}) || halt_now;

  // A byte written in the previous cycle may be the one being read back now.
  assign copy_byte = !inside_q ? '0 : (fwd_hit ? fwd_data : ram_q);

  assign rd_en = (accept && !halted && phase == PH_TOKEN_HIGH) ||
                 (state == ST_COPY && slot_free && !copy_stop);
  assign rd_addr = (state == ST_COPY) ? src_step : src_start;
  assign wr_en = slot_free && (state == ST_LIT || state == ST_COPY);
  assign wr_data = (state == ST_LIT) ? lit_byte : copy_byte;

  assign flag_shift = {flag_bits[BYTE_W-2:0], 1'b0};
  assign flags_dec = flags_left - 4'd1;
  assign phase_after = (flags_dec == 4'd0) ? PH_CONTROL : PH_ITEM;

  lzss_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_history (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (out_count[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_CONTROL;
      max_output <= MAX_OUTPUT_RESET;
      out_count  <= '0;
      flag_bits  <= '0;
      flags_left <= '0;
      token_low  <= '0;
      halted     <= 1'b0;
      fwd_hit    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_output <= cfg_wr_data;
      end
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_q <= in_ch.in_last;
            state <= in_ch.in_last ? ST_END : ST_IDLE;
            if (!halted) begin
              case (phase)
                PH_CONTROL: begin
                  flag_bits  <= in_ch.in_byte;
                  flags_left <= FLAG_COUNT;
                  phase      <= PH_ITEM;
                end
                PH_ITEM: begin
                  if (flag_bits[BYTE_W-1]) begin
                    token_low <= in_ch.in_byte;
                    phase     <= PH_TOKEN_HIGH;
                  end else begin
                    lit_byte <= in_ch.in_byte;
                    state    <= ST_LIT;
                  end
                end
                PH_TOKEN_HIGH: begin
                  src       <= src_start;
                  remaining <= copy_len;
                  inside_q  <= ref_inside;
                  fwd_hit   <= 1'b0;
                  state     <= ST_COPY;
                end
                default: begin
                  phase <= PH_CONTROL;
                end
              endcase
            end
          end
        end

        ST_LIT: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            out_byte     <= lit_byte;
            out_dv       <= 1'b1;
            out_run_last <= !last_q;
            out_end      <= 1'b0;
            out_total    <= count_inc;
            out_count    <= count_inc;
            halted       <= halt_now;
            flag_bits    <= flag_shift;
            flags_left   <= flags_dec;
            phase        <= phase_after;
            state        <= last_q ? ST_END : ST_IDLE;
          end
        end

        ST_COPY: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            out_byte     <= copy_byte;
            out_dv       <= 1'b1;
            out_run_last <= copy_stop && !last_q;
            out_end      <= 1'b0;
            out_total    <= count_inc;
            out_count    <= count_inc;
            halted       <= halt_now;
            remaining    <= remaining - {{(LEN_W-1){1'b0}}, 1'b1};
            src          <= src_step;
            fwd_hit      <= !copy_stop && (src_step == out_count[ADDR_W-1:0]);
            fwd_data     <= copy_byte;
            if (copy_stop) begin
              flag_bits  <= flag_shift;
              flags_left <= flags_dec;
              phase      <= phase_after;
              state      <= last_q ? ST_END : ST_IDLE;
            end
          end
        end

        ST_END: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            out_byte     <= '0;
            out_dv       <= 1'b0;
            out_run_last <= 1'b1;
            out_end      <= 1'b1;
            out_total    <= out_count;
            out_count    <= '0;
            phase        <= PH_CONTROL;
            flag_bits    <= '0;
            flags_left   <= '0;
            token_low    <= '0;
            halted       <= 1'b0;
            state        <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.out_byte   = out_byte;
  assign out_ch.data_valid = out_dv;
  assign out_ch.run_last   = out_run_last;
  assign out_ch.stream_end = out_end;
  assign out_ch.total_out  = out_total;

  a_copy_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_COPY |-> remaining != '0)
    else $error("copy running with no bytes left");

  a_halt_no_data: assert property (@(posedge clk) disable iff (rst)
    halted |-> state != ST_LIT && state != ST_COPY)
    else $error("data produced while halted");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_END && slot_free) |=>
      out_count == '0 && phase == PH_CONTROL && !halted && out_end)
    else $error("stream state not cleared after end result");

  a_fwd_only_copy: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> state == ST_COPY)
    else $error("forwarding flag left set outside a copy");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> out_count == $past(count_inc) && out_valid && out_dv)
    else $error("history write without matching data transfer");

endmodule

`default_nettype wire
